FILE: design/vmbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbd_pkg
// Shared opcodes, instruction classes and the decoded result record.
// ----------------------------------------------------------------------------
package vmbd_pkg;

    // Instruction classes, numbered densely in decode order.
    localparam logic [4:0] CLS_TURN_ON       = 5'd0;
    localparam logic [4:0] CLS_JMP           = 5'd4;
    localparam logic [4:0] CLS_WRITE_LOCAL   = 5'd12;
    localparam logic [4:0] CLS_READ_LOCAL    = 5'd13;
    localparam logic [4:0] CLS_READ_GLOBAL   = 5'd14;
    localparam logic [4:0] CLS_WRITE_GLOBAL  = 5'd15;
    localparam logic [4:0] CLS_SCRIPT_CALL   = 5'd16;
    localparam logic [4:0] CLS_SCRIPT_RESUME = 5'd17;
    localparam logic [4:0] CLS_SCRIPT_START  = 5'd18;
    localparam logic [4:0] CLS_SCRIPT_PAUSE  = 5'd19;
    localparam logic [4:0] CLS_SCRIPT_STOP   = 5'd20;
    localparam logic [4:0] CLS_PRIM          = 5'd21;

    // Opcodes as seen by the decoder (short forms and two-byte forms).
    localparam logic [7:0] OP_PIN_FIRST      = 8'h00;
    localparam logic [7:0] OP_PIN_LAST       = 8'h03;
    localparam logic [7:0] OP_READ_GLOBAL_S  = 8'h08;
    localparam logic [7:0] OP_WRITE_GLOBAL_S = 8'h09;
    localparam logic [7:0] OP_PRIM_LOW_S     = 8'h0A;
    localparam logic [7:0] OP_PRIM_HIGH_S    = 8'h0B;
    localparam logic [7:0] OP_SCRIPT_CALL_S  = 8'h0C;
    localparam logic [7:0] OP_SCRIPT_RUN_S   = 8'h0D;
    localparam logic [7:0] OP_SCRIPT_HALT_S  = 8'h0E;
    localparam logic [7:0] OP_JUMP_FIRST     = 8'hF0;
    localparam logic [7:0] OP_JUMP_LAST      = 8'hF7;
    localparam logic [7:0] OP_READ_GLOBAL_L  = 8'hF8;
    localparam logic [7:0] OP_WRITE_GLOBAL_L = 8'hF9;
    localparam logic [7:0] OP_PRIM_LOW_L     = 8'hFA;
    localparam logic [7:0] OP_PRIM_HIGH_L    = 8'hFB;
    localparam logic [7:0] OP_SCRIPT_CALL_L  = 8'hFC;
    localparam logic [7:0] OP_SCRIPT_RUN_L   = 8'hFD;
    localparam logic [7:0] OP_SCRIPT_HALT_L  = 8'hFE;
    localparam logic [7:0] OP_LOCAL_L        = 8'hFF;

    // Primitive number offsets per primitive opcode.
    localparam logic [9:0] PRIM_OFS_HIGH_S = 10'd16;
    localparam logic [9:0] PRIM_OFS_LOW_L  = 10'd32;
    localparam logic [9:0] PRIM_OFS_HIGH_L = 10'd288;

    // Unmapped primitive numbers.
    localparam logic [9:0] PRIM_GAP_FIRST = 10'h04A;
    localparam logic [9:0] PRIM_GAP_LAST  = 10'h04F;
    localparam logic [9:0] PRIM_MAX_KNOWN = 10'h059;

    // Nibble that marks the first byte of a two-byte instruction.
    localparam logic [3:0] LONG_PREFIX = 4'hF;

    typedef struct packed {
        logic [4:0] op_class;
        logic [9:0] prim_index;
        logic       prim_unknown;
        logic [6:0] stored_data;
    } vmbd_result_t;

endpackage

FILE: design/vmbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbd_decode
// Combinational decode of one opcode and its argument into a result record.
// ----------------------------------------------------------------------------
module vmbd_decode (
    input  logic [7:0]            op,
    input  logic [7:0]            arg,
    output vmbd_pkg::vmbd_result_t result
);
    import vmbd_pkg::*;

    logic       is_prim;
    logic [9:0] prim;
    logic [9:0] arg_wide;

    assign arg_wide = {2'b00, arg};

    always_comb begin
        result.op_class     = CLS_TURN_ON;
        result.stored_data  = arg[6:0];
        is_prim             = 1'b0;
        prim                = '0;
        unique case (op) inside
            [OP_PIN_FIRST:OP_PIN_LAST]: begin
                result.op_class = op[4:0];
            end
            [OP_JUMP_FIRST:OP_JUMP_LAST]: begin
                result.op_class = CLS_JMP + {2'b00, op[2:0]};
            end
            OP_LOCAL_L: begin
                result.op_class = arg[7] ? CLS_WRITE_LOCAL : CLS_READ_LOCAL;
            end
            OP_READ_GLOBAL_L, OP_READ_GLOBAL_S: begin
                result.op_class = CLS_READ_GLOBAL;
            end
            OP_WRITE_GLOBAL_L, OP_WRITE_GLOBAL_S: begin
                result.op_class = CLS_WRITE_GLOBAL;
            end
            OP_PRIM_LOW_S: begin
                is_prim = 1'b1;
                prim    = arg_wide;
            end
            OP_PRIM_HIGH_S: begin
                is_prim = 1'b1;
                prim    = arg_wide + PRIM_OFS_HIGH_S;
            end
            OP_PRIM_LOW_L: begin
                is_prim = 1'b1;
                prim    = arg_wide + PRIM_OFS_LOW_L;
            end
            OP_PRIM_HIGH_L: begin
                is_prim = 1'b1;
                prim    = arg_wide + PRIM_OFS_HIGH_L;
            end
            OP_SCRIPT_CALL_L, OP_SCRIPT_CALL_S: begin
                result.op_class = CLS_SCRIPT_CALL;
            end
            OP_SCRIPT_RUN_L: begin
                result.op_class = arg[7] ? CLS_SCRIPT_RESUME : CLS_SCRIPT_START;
            end
            OP_SCRIPT_RUN_S: begin
                // Short form: bit 3 selects, only three data bits remain.
                result.op_class    = arg[3] ? CLS_SCRIPT_RESUME : CLS_SCRIPT_START;
                result.stored_data = {4'b0000, arg[2:0]};
            end
            OP_SCRIPT_HALT_L: begin
                result.op_class = arg[7] ? CLS_SCRIPT_PAUSE : CLS_SCRIPT_STOP;
            end
            OP_SCRIPT_HALT_S: begin
                result.op_class    = arg[3] ? CLS_SCRIPT_PAUSE : CLS_SCRIPT_STOP;
                result.stored_data = {4'b0000, arg[2:0]};
            end
            default: begin
                result.op_class = CLS_TURN_ON;
            end
        endcase
        if (is_prim) begin
            result.op_class    = CLS_PRIM;
            result.stored_data = '0;
        end
        result.prim_index   = prim;
        result.prim_unknown = is_prim &&
                              (((prim >= PRIM_GAP_FIRST) && (prim <= PRIM_GAP_LAST)) ||
                               (prim > PRIM_MAX_KNOWN));
    end

endmodule

FILE: design/vm_bytecode_instruction_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_bytecode_instruction_decoder
// Streaming decoder for one- and two-byte virtual machine instructions.
// ----------------------------------------------------------------------------
// One bytecode byte enters per transfer on the slave side and the block
// accepts a transfer in every cycle in which s_tready is high. Each byte
// is captured in an input register, decoded combinationally and written
// to a result register, from which it is presented on the master side
// and held there until m_tready takes it.
// A byte below 0x80 is a complete instruction (3-bit opcode, 5-bit argument);
// a byte from 0x80 to 0xEF is complete as well (4-bit opcode, 4-bit
// argument); a byte with high nibble 0xF is held and combined with the next
// byte, and produces no result of its own. A transfer with the timeout flag
// set in s_tuser drops any held byte and produces no result. The input
// register can still take a transfer while a finished result waits on m_tready;
// back pressure reaches s_tready only when both registers are full.
// ----------------------------------------------------------------------------
module vm_bytecode_instruction_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave side.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tuser,   // [0] timed_out
    // Master side.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] prim_index, [16:10] stored_data,
                                   // [23:17] signed_arg (a copy of stored_data)
    output logic [5:0]  m_tuser    // [4:0] op_class, [5] prim_unknown
);
    import vmbd_pkg::*;

    // Input register stage.
    logic       in_valid_reg,   in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_timeout_reg;

    // Pending first byte of a two-byte instruction.
    logic       awaiting_reg,   awaiting_next;
    logic [7:0] held_reg,       held_next;

    // Result register stage.
    logic         out_valid_reg, out_valid_next;
    vmbd_result_t out_result_reg;

    logic         advance;
    logic         process;
    logic         first_of_pair;
    logic         produce;
    logic [7:0]   dec_op;
    logic [7:0]   dec_arg;
    vmbd_result_t dec_result;

    // The decode stage moves whenever the result register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign first_of_pair = !awaiting_reg && (in_byte_reg[7:4] == LONG_PREFIX);
    assign produce       = !in_timeout_reg && !first_of_pair;

    // Opcode and argument: held byte plus this byte, or a split of this byte.
    always_comb begin
        if (awaiting_reg) begin
            dec_op  = held_reg;
            dec_arg = in_byte_reg;
        end else if (in_byte_reg[7]) begin
            dec_op  = {4'b0000, in_byte_reg[7:4]};
            dec_arg = {4'b0000, in_byte_reg[3:0]};
        end else begin
            dec_op  = {5'b00000, in_byte_reg[7:5]};
            dec_arg = {3'b000, in_byte_reg[4:0]};
        end
    end

    vmbd_decode u_decode (
        .op     (dec_op),
        .arg    (dec_arg),
        .result (dec_result)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        awaiting_next  = awaiting_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        if (process) begin
            in_valid_next = 1'b0;
            if (in_timeout_reg || awaiting_reg) begin
                awaiting_next = 1'b0;
                held_next     = '0;
            end else if (first_of_pair) begin
                awaiting_next = 1'b1;
                held_next     = in_byte_reg;
            end
            out_valid_next = produce;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            awaiting_reg  <= awaiting_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_timeout_reg <= s_tuser;
        end
        if (process && produce) begin
            out_result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.stored_data, out_result_reg.stored_data,
                       out_result_reg.prim_index};
    assign m_tuser  = {out_result_reg.prim_unknown, out_result_reg.op_class};

    // A timeout transfer always leaves no byte pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_timeout_reg) |=> !awaiting_reg)
        else $error("pending byte survived a timeout");

    // Only a first byte with the long prefix can be pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        awaiting_reg |-> (held_reg[7:4] == LONG_PREFIX))
        else $error("held byte lacks the long prefix");

    // The first byte of a pair never yields a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && !in_timeout_reg && first_of_pair) |=> !m_tvalid)
        else $error("first byte of a pair produced a result");

    // The unknown flag is only ever raised on primitives.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[5]) |-> (m_tuser[4:0] == CLS_PRIM))
        else $error("unknown flag on a non-primitive");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bytecode instruction decoder.
// ----------------------------------------------------------------------------
// Code bytes are streamed into the slave side. Each transfer is also fed to a
// decoder model in this bench, which keeps its own copy of the pending-byte
// state and queues the decoded instruction that the block should produce.
// Every transfer on the master side is compared field by field with the
// oldest queued instruction. Directed tests cover the extremes of the short
// and long forms, timeouts and a pause in the middle of a pair; random
// traffic then runs under four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import vmbd_pkg::*;

    localparam int unsigned CLK_HALF_NS   = 10;
    localparam int unsigned SETTLE_CYCLES = 8;     // extra wait once the queue is empty
    localparam int unsigned ITEMS_PER_MIX = 275;
    localparam int unsigned MAX_ERR_LINES = 40;
    localparam logic [7:0]  SHORT_LIMIT   = 8'h80; // first byte of the 4-bit opcode forms

    typedef struct packed {
        logic [4:0] op_class;
        logic [9:0] prim_index;
        logic       prim_unknown;
        logic [6:0] stored_data;
        logic [6:0] signed_arg;
    } decoded_instr_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] code_byte
    logic        s_tuser  = 1'b0;    // [0] timed_out
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [9:0] prim_index, [16:10] stored_data,
                                     // [23:17] signed_arg
    logic [5:0]  m_tuser;            // [4:0] op_class, [5] prim_unknown

    // Decoder model state: a long-form first byte waiting for its argument.
    logic        pair_pending = 1'b0;
    logic [7:0]  pair_opcode  = 8'h00;

    decoded_instr_t expected_instrs[$];

    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned error_count    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned timeouts_sent  = 0;
    int unsigned pairs_decoded  = 0;
    int unsigned unknown_prims  = 0;
    int unsigned results_seen   = 0;

    vm_bytecode_instruction_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Generous cap: a correct run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_ERR_LINES) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Decode one opcode (short form 0..14 or long form 0xF0..0xFF) with its
    // argument, as the block is specified to.
    function automatic decoded_instr_t decode_instr(input logic [7:0] op,
                                                    input logic [7:0] arg);
        decoded_instr_t r;
        logic [9:0]     prim;
        logic [7:0]     data;
        logic           is_prim;
        r       = '0;
        prim    = '0;
        data    = arg;
        is_prim = 1'b0;
        if (op <= OP_PIN_LAST) begin
            r.op_class = CLS_TURN_ON + 5'(op);
        end else if (op >= OP_JUMP_FIRST && op <= OP_JUMP_LAST) begin
            r.op_class = CLS_JMP + 5'(op - OP_JUMP_FIRST);
        end else begin
            case (op)
                OP_LOCAL_L: begin
                    r.op_class = arg[7] ? CLS_WRITE_LOCAL : CLS_READ_LOCAL;
                    data = {1'b0, arg[6:0]};
                end
                OP_READ_GLOBAL_L, OP_READ_GLOBAL_S: r.op_class = CLS_READ_GLOBAL;
                OP_WRITE_GLOBAL_L, OP_WRITE_GLOBAL_S: r.op_class = CLS_WRITE_GLOBAL;
                OP_PRIM_LOW_S: begin
                    is_prim = 1'b1;
                    prim = {2'b00, arg};
                end
                OP_PRIM_HIGH_S: begin
                    is_prim = 1'b1;
                    prim = {2'b00, arg} + PRIM_OFS_HIGH_S;
                end
                OP_PRIM_LOW_L: begin
                    is_prim = 1'b1;
                    prim = {2'b00, arg} + PRIM_OFS_LOW_L;
                end
                OP_PRIM_HIGH_L: begin
                    is_prim = 1'b1;
                    prim = {2'b00, arg} + PRIM_OFS_HIGH_L;
                end
                OP_SCRIPT_CALL_L, OP_SCRIPT_CALL_S: r.op_class = CLS_SCRIPT_CALL;
                OP_SCRIPT_RUN_L: begin
                    r.op_class = arg[7] ? CLS_SCRIPT_RESUME : CLS_SCRIPT_START;
                    data = {1'b0, arg[6:0]};
                end
                OP_SCRIPT_RUN_S: begin
                    // Short form: bit 3 selects, three data bits remain.
                    r.op_class = arg[3] ? CLS_SCRIPT_RESUME : CLS_SCRIPT_START;
                    data = {5'b0, arg[2:0]};
                end
                OP_SCRIPT_HALT_L: begin
                    r.op_class = arg[7] ? CLS_SCRIPT_PAUSE : CLS_SCRIPT_STOP;
                    data = {1'b0, arg[6:0]};
                end
                OP_SCRIPT_HALT_S: begin
                    r.op_class = arg[3] ? CLS_SCRIPT_PAUSE : CLS_SCRIPT_STOP;
                    data = {5'b0, arg[2:0]};
                end
                default: r.op_class = CLS_TURN_ON;
            endcase
        end
        if (is_prim) begin
            r.op_class     = CLS_PRIM;
            r.prim_index   = prim;
            r.prim_unknown = (prim >= PRIM_GAP_FIRST && prim <= PRIM_GAP_LAST) ||
                             (prim > PRIM_MAX_KNOWN);
            data = 8'h00;
        end
        // The breakpoint bit never survives; jumps keep the low seven bits.
        r.stored_data = data[6:0];
        r.signed_arg  = data[6:0];
        return r;
    endfunction

    // Advance the model by one accepted code byte.
    function automatic void predict_decode(input logic [7:0] code,
                                           input logic       flag_timeout);
        decoded_instr_t r;
        logic           has_result;
        has_result = 1'b0;
        bytes_sent++;
        if (flag_timeout) begin
            // A timeout drops any held first byte; the byte itself is ignored.
            timeouts_sent++;
            pair_pending = 1'b0;
            pair_opcode  = 8'h00;
        end else if (pair_pending) begin
            r = decode_instr(pair_opcode, code);
            has_result   = 1'b1;
            pair_pending = 1'b0;
            pair_opcode  = 8'h00;
            pairs_decoded++;
        end else if (code < SHORT_LIMIT) begin
            r = decode_instr({5'b0, code[7:5]}, {3'b0, code[4:0]});
            has_result = 1'b1;
        end else if (code[7:4] == LONG_PREFIX) begin
            pair_pending = 1'b1;
            pair_opcode  = code;
        end else begin
            r = decode_instr({4'b0, code[7:4]}, {4'b0, code[3:0]});
            has_result = 1'b1;
        end
        if (has_result) begin
            if (r.prim_unknown) begin
                unknown_prims++;
            end
            expected_instrs.push_back(r);
        end
    endfunction

    // Sends one code byte. s_tvalid stays high after the transfer, so that a
    // following byte with no gap is offered without a dead cycle.
    task automatic send_code(input logic [7:0] code, input logic flag_timeout);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= flag_timeout;
        do @(posedge aclk); while (!s_tready);
        predict_decode(code, flag_timeout);
    endtask

    // Stop sending and let every queued instruction come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_instrs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_arg();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One-byte instructions: both opcode widths, argument extremes, and the
    // selector bit of the short script forms.
    task automatic test_short_forms();
        send_code(8'h00, 1'b0);   // turn on, argument zero
        send_code(8'h7F, 1'b0);   // read pin, argument all ones
        send_code(8'h5A, 1'b0);   // write pin
        send_code(8'h8F, 1'b0);   // read global, short form
        send_code(8'h90, 1'b0);   // write global, short form
        send_code(8'hA0, 1'b0);   // lowest primitive
        send_code(8'hBF, 1'b0);   // high short primitive range end
        send_code(8'hD8, 1'b0);   // script resume, data zero
        send_code(8'hE7, 1'b0);   // script stop, data seven
        wait_for_drain();
    endtask

    // Two-byte instructions: jump with a negative offset, local write with
    // the selector set, a primitive in the unmapped gap, the largest
    // primitive, and a pause with every data bit set.
    task automatic test_long_forms();
        send_code(OP_JUMP_FIRST, 1'b0);
        send_code(8'h80, 1'b0);
        send_code(OP_LOCAL_L, 1'b0);
        send_code(8'h80, 1'b0);
        send_code(OP_PRIM_LOW_L, 1'b0);
        send_code(8'h2A, 1'b0);
        send_code(OP_PRIM_HIGH_L, 1'b0);
        send_code(8'hFF, 1'b0);
        send_code(OP_SCRIPT_HALT_L, 1'b0);
        send_code(8'hFF, 1'b0);
        wait_for_drain();
    endtask

    // A timeout on an idle decoder, and a timeout that abandons a pair.
    task automatic test_timeouts();
        send_code(8'hFF, 1'b1);
        send_code(8'hF5, 1'b0);
        send_code(8'h00, 1'b1);
        wait_for_drain();
    endtask

    // The sender holds off until nothing is outstanding, with the first byte
    // of a pair held inside the block across the pause.
    task automatic test_pause_mid_pair();
        send_code(8'h45, 1'b0);
        send_code(8'hF3, 1'b0);
        wait_for_drain();
        send_code(8'h81, 1'b0);
        wait_for_drain();
    endtask

    // Mostly well-formed instruction streams with random content, plus
    // timeouts, broken pairs and raw noise bytes.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall);
        int unsigned counted;
        int unsigned kind;
        counted       = 0;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        while (counted < ITEMS_PER_MIX) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                send_code(8'($urandom_range(8'hEF)), 1'b0);
                counted += 1;
            end else if (kind < 80) begin
                send_code({LONG_PREFIX, 4'($urandom_range(15))}, 1'b0);
                send_code(pick_arg(), 1'b0);
                counted += 2;
            end else if (kind < 88) begin
                send_code(8'($urandom_range(255)), 1'b1);
            end else if (kind < 94) begin
                send_code({LONG_PREFIX, 4'($urandom_range(15))}, 1'b0);
                send_code(8'($urandom_range(255)), 1'b1);
                counted += 1;
            end else begin
                send_code(8'($urandom_range(255)), 1'b0);
                counted += 1;
            end
        end
        wait_for_drain();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker: every master-side transfer against the oldest
    // queued instruction.
    always @(posedge aclk) begin
        decoded_instr_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_instrs.size() == 0) begin
                report_error($sformatf("unexpected result tdata=%h tuser=%h",
                                       m_tdata, m_tuser));
            end else begin
                want = expected_instrs.pop_front();
                if (m_tuser[4:0] !== want.op_class) begin
                    report_error($sformatf("op_class expected %0d got %0d",
                                           want.op_class, m_tuser[4:0]));
                end
                if (m_tuser[5] !== want.prim_unknown) begin
                    report_error($sformatf("prim_unknown expected %0d got %0d",
                                           want.prim_unknown, m_tuser[5]));
                end
                if (m_tdata[9:0] !== want.prim_index) begin
                    report_error($sformatf("prim_index expected %0d got %0d",
                                           want.prim_index, m_tdata[9:0]));
                end
                if (m_tdata[16:10] !== want.stored_data) begin
                    report_error($sformatf("stored_data expected %h got %h",
                                           want.stored_data, m_tdata[16:10]));
                end
                if (m_tdata[23:17] !== want.signed_arg) begin
                    report_error($sformatf("signed_arg expected %h got %h",
                                           want.signed_arg, m_tdata[23:17]));
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_forms();
        test_long_forms();
        test_timeouts();
        test_pause_mid_pair();
        test_random_traffic(0, 0);
        test_random_traffic(70, 0);
        test_random_traffic(0, 70);
        test_random_traffic(34, 34);
        wait_for_drain();

        if (expected_instrs.size() != 0) begin
            report_error($sformatf("%0d decoded instructions never came out",
                                   expected_instrs.size()));
        end
        $display("Streamed %0d code bytes (%0d timeouts, %0d two-byte instructions)",
                 bytes_sent, timeouts_sent, pairs_decoded);
        $display("Checked %0d results, %0d of them unmapped primitives, over four pacing mixes",
                 results_seen, unknown_prims);
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: vm_bytecode_instruction_decoder.f
design/vmbd_pkg.sv
design/vmbd_decode.sv
design/vm_bytecode_instruction_decoder.sv
bench/tb_top.sv
